### sv/sdspi_pkg.sv
// shared types and constants for the sd card spi host
// no dependencies; used by the top level, its port checker and the testbench
package sdspi_pkg;

	// item kinds on the input stream
	localparam logic [1:0] KIND_XFER  = 2'd0;
	localparam logic [1:0] KIND_INIT  = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;
	localparam logic [1:0] KIND_TICK  = 2'd3;

	// completion status codes
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_IDLE_REJ    = 3'd1;
	localparam logic [2:0] ST_INIT_TMO    = 3'd2;
	localparam logic [2:0] ST_NOT_READY   = 3'd3;
	localparam logic [2:0] ST_READ_REJ    = 3'd4;
	localparam logic [2:0] ST_TOKEN_TMO   = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_RESP_TMO   = 2'd0;
	localparam logic [1:0] REG_INIT_TMO   = 2'd1;
	localparam logic [1:0] REG_RETRY_DLY  = 2'd2;

	// register reset values
	localparam logic [15:0] RESP_TMO_RST  = 16'd1000;
	localparam logic [15:0] INIT_TMO_RST  = 16'd2000;
	localparam logic [7:0]  RETRY_DLY_RST = 8'd10;

	// sd command indexes
	localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
	localparam logic [5:0] CMD_SEND_IF    = 6'd8;
	localparam logic [5:0] CMD_READ_BLK   = 6'd17;
	localparam logic [5:0] CMD_APP        = 6'd55;
	localparam logic [5:0] ACMD_OP_COND   = 6'd41;

	// protocol bytes and arguments
	localparam logic [7:0]  BYTE_IDLE     = 8'hFF;
	localparam logic [7:0]  BYTE_TOKEN    = 8'hFE;
	localparam logic [7:0]  BYTE_CMD_MARK = 8'h40;
	localparam logic [7:0]  CRC_CMD0      = 8'h95;
	localparam logic [7:0]  CRC_CMD8      = 8'h87;
	localparam logic [7:0]  R1_IDLE       = 8'h01;
	localparam logic [7:0]  R1_READY      = 8'h00;
	localparam logic [31:0] ARG_SEND_IF   = 32'h0000_01AA;
	localparam logic [31:0] ARG_HCS       = 32'h4000_0000;
	localparam int unsigned CMD_FRAME_BYTES = 6;
	localparam int unsigned R7_BYTES      = 4;
	localparam int unsigned CRC_BYTES     = 2;

	// parameter defaults
	localparam int unsigned SECTOR_BYTES_DEF = 512;
	localparam int unsigned DUMMY_BYTES_DEF  = 10;

	// stream widths
	localparam int unsigned S_TDATA_W = 40;
	localparam int unsigned M_TDATA_W = 24;

endpackage

### sv/sd_spi_host_init_and_block_read_top.sv
// sd card host in spi mode: card init sequence and single-block read
// depends on sdspi_pkg
//
// channel  dir  handshake                 payload
// s_*      in   s_tvalid / s_tready       tuser kind, tdata rx byte and sector
// m_*      out  m_tvalid / m_tready       tuser tx/data flags, tdata, tlast
// cfg_*    in   cfg_valid / cfg_ready     cfg_index, cfg_data
//
// every word is answered by one result word: the state update and the result are
// computed from the input word in one pass and land in the result register.
// a new word is taken every cycle while the result register is empty or drained.
// a stall on m_* holds s_tready low until the pending result is taken.
// reset clears the sequencer to idle, the card to not initialized and the
// registers to their defaults; cfg_ready is always high.
module sd_spi_host_init_and_block_read_top #(
	parameter int unsigned SECTOR_BYTES = sdspi_pkg::SECTOR_BYTES_DEF,
	parameter int unsigned DUMMY_BYTES  = sdspi_pkg::DUMMY_BYTES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input stream
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [1:0]                       s_tuser,   // command
	input  logic [sdspi_pkg::S_TDATA_W-1:0]  s_tdata,   // rx_byte[7:0], sector[39:8]
	// result stream
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [1:0]                       m_tuser,   // tx_valid[0], data_valid[1]
	output logic [sdspi_pkg::M_TDATA_W-1:0]  m_tdata,   // tx_byte[7:0], cs_asserted[8],
	                                                    // data_byte[16:9], done_res[17],
	                                                    // status[20:18], busy_res[21]
	output logic                             m_tlast,   // data_last
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [1:0]                       cfg_index,
	input  logic [15:0]                      cfg_data
);
	import sdspi_pkg::*;

	localparam int unsigned CW = $clog2(SECTOR_BYTES + 1);

	typedef enum logic [3:0] {
		PH_IDLE, PH_DUMMY, PH_READY, PH_CMD, PH_RESP, PH_R7,
		PH_DELAY, PH_TOKEN, PH_DATA, PH_CRC, PH_EXTRA
	} phase_t;

	// configuration registers
	logic [15:0] resp_tmo_q, init_tmo_q;
	logic [7:0]  retry_dly_q;

	// sequencer state
	phase_t      phase_q, phase_d;
	logic [CW-1:0] cnt_q, cnt_d, cnt_inc;
	logic [15:0] wait_q, wait_d, init_q, init_d;
	logic        ready_q, ready_d;
	logic [5:0]  idx_q, idx_d;
	logic [31:0] arg_q, arg_d;

	// per-word results
	logic        tx_v, dat_v, dat_l, done, timed_out;
	logic [7:0]  tx_b, dat_b, resp;
	logic [2:0]  st;
	logic        do_begin, do_finish;
	logic [5:0]  begin_idx;
	logic [31:0] begin_arg;
	logic [2:0]  finish_st;

	logic        accept;
	logic [1:0]  kind;
	logic [7:0]  rx;
	logic [31:0] sector;

	assign kind   = s_tuser;
	assign rx     = s_tdata[7:0];
	assign sector = s_tdata[39:8];
	assign s_tready  = !m_tvalid || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign cnt_inc   = cnt_q + CW'(1);

	// byte k of the current command frame
	function automatic logic [7:0] frame_byte(input logic [CW-1:0] k,
			input logic [5:0] idx, input logic [31:0] arg);
		logic [7:0] b;
		case (k)
			CW'(0): b = BYTE_CMD_MARK | {2'b00, idx};
			CW'(1): b = arg[31:24];
			CW'(2): b = arg[23:16];
			CW'(3): b = arg[15:8];
			CW'(4): b = arg[7:0];
			default: begin
				if (idx == CMD_GO_IDLE)      b = CRC_CMD0;
				else if (idx == CMD_SEND_IF) b = CRC_CMD8;
				else                         b = BYTE_IDLE;
			end
		endcase
		return b;
	endfunction

	// next state and result for one word
	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_q;
		wait_d  = wait_q;
		init_d  = init_q;
		ready_d = ready_q;
		idx_d   = idx_q;
		arg_d   = arg_q;
		tx_v = 1'b0; tx_b = 8'h00;
		dat_v = 1'b0; dat_b = 8'h00; dat_l = 1'b0;
		do_begin = 1'b0; begin_idx = CMD_GO_IDLE; begin_arg = 32'd0;
		do_finish = 1'b0; finish_st = ST_OK;
		timed_out = wait_q >= resp_tmo_q;
		resp = (rx[7] == 1'b0) ? rx : BYTE_IDLE;

		unique case (kind)
			KIND_XFER: begin
				unique case (phase_q)
					PH_DUMMY: begin
						cnt_d = cnt_inc;
						if (cnt_inc < CW'(DUMMY_BYTES)) begin
							tx_v = 1'b1; tx_b = BYTE_IDLE;
						end else begin
							do_begin = 1'b1; begin_idx = CMD_GO_IDLE; begin_arg = 32'd0;
						end
					end
					PH_READY: begin
						tx_v = 1'b1;
						if (rx == BYTE_IDLE || timed_out) begin
							phase_d = PH_CMD;
							cnt_d   = '0;
							tx_b    = frame_byte('0, idx_q, arg_q);
						end else begin
							tx_b = BYTE_IDLE;
						end
					end
					PH_CMD: begin
						cnt_d = cnt_inc;
						tx_v  = 1'b1;
						if (cnt_inc < CW'(CMD_FRAME_BYTES)) begin
							tx_b = frame_byte(cnt_inc, idx_q, arg_q);
						end else begin
							phase_d = PH_RESP;
							wait_d  = '0;
							tx_b    = BYTE_IDLE;
						end
					end
					PH_RESP: begin
						if (rx[7] == 1'b0 || timed_out) begin
							// response decode per command
							unique case (idx_q)
								CMD_GO_IDLE: begin
									if (resp != R1_IDLE) begin
										do_finish = 1'b1; finish_st = ST_IDLE_REJ;
									end else begin
										do_begin = 1'b1; begin_idx = CMD_SEND_IF;
										begin_arg = ARG_SEND_IF;
									end
								end
								CMD_SEND_IF: begin
									if (resp == R1_IDLE) begin
										phase_d = PH_R7;
										cnt_d   = '0;
										tx_v = 1'b1; tx_b = BYTE_IDLE;
									end else begin
										init_d = '0;
										do_begin = 1'b1; begin_idx = CMD_APP;
									end
								end
								CMD_APP: begin
									do_begin = 1'b1; begin_idx = ACMD_OP_COND;
									begin_arg = ARG_HCS;
								end
								ACMD_OP_COND: begin
									if (resp == R1_READY) begin
										ready_d = 1'b1;
										do_finish = 1'b1; finish_st = ST_OK;
									end else if (retry_dly_q == 8'd0) begin
										if (init_q >= init_tmo_q) begin
											do_finish = 1'b1; finish_st = ST_INIT_TMO;
										end else begin
											do_begin = 1'b1; begin_idx = CMD_APP;
										end
									end else begin
										phase_d = PH_DELAY;
										wait_d  = '0;
									end
								end
								default: begin
									if (resp != R1_READY) begin
										do_finish = 1'b1; finish_st = ST_READ_REJ;
									end else begin
										phase_d = PH_TOKEN;
										wait_d  = '0;
										tx_v = 1'b1; tx_b = BYTE_IDLE;
									end
								end
							endcase
						end else begin
							tx_v = 1'b1; tx_b = BYTE_IDLE;
						end
					end
					PH_R7: begin
						cnt_d = cnt_inc;
						if (cnt_inc < CW'(R7_BYTES)) begin
							tx_v = 1'b1; tx_b = BYTE_IDLE;
						end else begin
							init_d = '0;
							do_begin = 1'b1; begin_idx = CMD_APP;
						end
					end
					PH_TOKEN: begin
						if (rx == BYTE_TOKEN) begin
							phase_d = PH_DATA;
							cnt_d   = '0;
							tx_v = 1'b1; tx_b = BYTE_IDLE;
						end else if (timed_out) begin
							do_finish = 1'b1; finish_st = ST_TOKEN_TMO;
						end else begin
							tx_v = 1'b1; tx_b = BYTE_IDLE;
						end
					end
					PH_DATA: begin
						dat_v = 1'b1;
						dat_b = rx;
						dat_l = cnt_q == CW'(SECTOR_BYTES - 1);
						cnt_d = cnt_inc;
						if (cnt_inc >= CW'(SECTOR_BYTES)) begin
							phase_d = PH_CRC;
							cnt_d   = '0;
						end
						tx_v = 1'b1; tx_b = BYTE_IDLE;
					end
					PH_CRC: begin
						cnt_d = cnt_inc;
						if (cnt_inc >= CW'(CRC_BYTES)) phase_d = PH_EXTRA;
						tx_v = 1'b1; tx_b = BYTE_IDLE;
					end
					PH_EXTRA: begin
						do_finish = 1'b1; finish_st = ST_OK;
					end
					default: begin
						// idle and retry delay ignore finished exchanges
					end
				endcase
			end
			KIND_INIT: begin
				if (phase_q == PH_IDLE) begin
					phase_d = PH_DUMMY;
					cnt_d   = '0;
					tx_v = 1'b1; tx_b = BYTE_IDLE;
				end
			end
			KIND_READ: begin
				if (phase_q == PH_IDLE) begin
					if (!ready_q) begin
						do_finish = 1'b1; finish_st = ST_NOT_READY;
					end else begin
						do_begin = 1'b1; begin_idx = CMD_READ_BLK; begin_arg = sector;
					end
				end
			end
			default: begin
				// tick: saturating timers, may end the retry delay
				if (wait_q != 16'hFFFF) wait_d = wait_q + 16'd1;
				if (init_q != 16'hFFFF) init_d = init_q + 16'd1;
				if (phase_q == PH_DELAY && wait_d >= {8'd0, retry_dly_q}) begin
					if (init_d >= init_tmo_q) begin
						do_finish = 1'b1; finish_st = ST_INIT_TMO;
					end else begin
						do_begin = 1'b1; begin_idx = CMD_APP;
					end
				end
			end
		endcase

		// start of a command: poll for a ready card first
		if (do_begin) begin
			idx_d   = begin_idx;
			arg_d   = begin_arg;
			phase_d = PH_READY;
			wait_d  = '0;
			cnt_d   = '0;
			tx_v = 1'b1; tx_b = BYTE_IDLE;
		end
		if (do_finish) phase_d = PH_IDLE;
		done = do_finish;
		st   = do_finish ? finish_st : ST_OK;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resp_tmo_q  <= RESP_TMO_RST;
			init_tmo_q  <= INIT_TMO_RST;
			retry_dly_q <= RETRY_DLY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_RESP_TMO:  resp_tmo_q  <= cfg_data;
				REG_INIT_TMO:  init_tmo_q  <= cfg_data;
				REG_RETRY_DLY: retry_dly_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			wait_q  <= '0;
			init_q  <= '0;
			ready_q <= 1'b0;
			idx_q   <= CMD_GO_IDLE;
			arg_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			wait_q  <= wait_d;
			init_q  <= init_d;
			ready_q <= ready_d;
			idx_q   <= idx_d;
			arg_q   <= arg_d;
		end
	end

	// result register
	logic cs;
	assign cs = phase_d == PH_READY || phase_d == PH_CMD || phase_d == PH_RESP ||
		phase_d == PH_R7 || phase_d == PH_TOKEN || phase_d == PH_DATA ||
		phase_d == PH_CRC;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (accept) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tuser <= {dat_v, tx_v};
			m_tdata <= {2'b00, phase_d != PH_IDLE, st, done, dat_b, cs, tx_b};
			m_tlast <= dat_l;
		end
	end

endmodule

### sv/sdspi_port_check.sv
// port-level checker for the sd card spi host, bound to the top level
// depends on sdspi_pkg and sd_spi_host_init_and_block_read_top
module sdspi_port_check (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [1:0]  m_tuser,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);
	import sdspi_pkg::*;

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// a sector byte is only seen with chip select low and the next exchange requested
	a_data_cs: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tuser[0] && m_tdata[8] && m_tdata[21])
		else $error("sector byte outside an active read");

	// a finished operation leaves the host idle with chip select high
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[17] |-> !m_tdata[21] && !m_tdata[8] && !m_tuser[0])
		else $error("done while still busy");

	// error status only on completion, last only on data
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[20:18] != ST_OK || m_tlast) |->
			(m_tdata[17] || m_tlast == 1'b1) && (!m_tlast || m_tuser[1]))
		else $error("status or last without completion or data");

	// no exchange request means a zero tx byte
	a_tx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'h00)
		else $error("tx byte set without a request");

endmodule

bind sd_spi_host_init_and_block_read_top sdspi_port_check u_port_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tuser  (m_tuser),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

### dv/tb.sv
// self-checking testbench for the sd card spi host top level
// depends on sdspi_pkg and sd_spi_host_init_and_block_read_top; drives a card-like byte stream
`timescale 1ns / 100ps

module tb;
	import sdspi_pkg::*;

	localparam int unsigned SECT_N   = SECTOR_BYTES_DEF;
	localparam int unsigned DUMMY_N  = DUMMY_BYTES_DEF;
	localparam int unsigned LIMIT    = 400000;
	localparam int          HOLD_CYCLES = 250;
	localparam logic [1:0]  REG_NONE = 2'd3;   // index with no register behind it

	// sequencer phases of the card host
	typedef enum logic [3:0] {
		SEQ_IDLE, SEQ_DUMMY, SEQ_READY, SEQ_CMD, SEQ_RESP, SEQ_R7,
		SEQ_DELAY, SEQ_TOKEN, SEQ_DATA, SEQ_CRC, SEQ_EXTRA
	} seq_t;

	// one result word, unpacked
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       cs;
		logic       data_valid;
		logic [7:0] data_byte;
		logic       data_last;
		logic       done;
		logic [2:0] status;
		logic       busy;
	} card_res_t;

	// directed stimulus row; typed rows carry their own expected result
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  rx;
		logic [31:0] sector;
		logic        typed;
		logic        tx_valid;
		logic [7:0]  tx_byte;
		logic        cs;
		logic        done;
		logic [2:0]  status;
		logic        busy;
	} dir_row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [1:0]  s_tuser   = '0;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [1:0]  m_tuser;
	logic [M_TDATA_W-1:0] m_tdata;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data  = '0;

	sd_spi_host_init_and_block_read_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// host model state and its register copies
	logic [15:0] resp_tmo  = RESP_TMO_RST;
	logic [15:0] init_tmo  = INIT_TMO_RST;
	logic [7:0]  retry_dly = RETRY_DLY_RST;
	seq_t        seq       = SEQ_IDLE;
	logic [9:0]  bcnt      = '0;
	logic [15:0] wticks    = '0;
	logic [15:0] iticks    = '0;
	logic        card_rdy  = 1'b0;
	logic [5:0]  cur_idx   = '0;
	logic [31:0] cur_arg   = '0;
	card_res_t   pr;

	card_res_t   card_q[$];
	card_res_t   got_exp;
	int          errs       = 0;
	int          cyc        = 0;
	int          src_idle   = 0;
	int          sink_stall = 0;
	int          hold_left  = 0;
	logic        hold_req   = 1'b0;
	logic        hold_taken = 1'b0;

	dir_row_t dir_tab [25] = '{
		// read before init, stray exchange, idle tick, init, read while busy
		'{KIND_READ, 8'h00, 32'hFFFF_FFFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, ST_NOT_READY, 1'b0},
		'{KIND_XFER, 8'hFF, 32'h0000_0000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_TICK, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_INIT, 8'h00, 32'hFFFF_FFFF, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b0, ST_OK, 1'b1},
		'{KIND_READ, 8'h00, 32'h0000_0000, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b1},
		// dummy clocks with chip select high; the last exchange starts cmd0
		'{KIND_XFER, 8'h00, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_XFER, 8'hFF, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_XFER, 8'h00, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_XFER, 8'hFF, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_XFER, 8'h00, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_XFER, 8'hFF, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_XFER, 8'h00, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_XFER, 8'hFF, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_XFER, 8'h00, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_XFER, 8'hFF, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		// ready poll: busy card, then ready
		'{KIND_XFER, 8'h00, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_XFER, 8'hFF, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		// cmd0 frame
		'{KIND_XFER, 8'hA5, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_XFER, 8'h5A, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_XFER, 8'hFF, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_XFER, 8'h00, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_XFER, 8'h80, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_XFER, 8'h7F, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		// response poll, then a wrong idle response
		'{KIND_XFER, 8'h80, 32'h0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_OK, 1'b0},
		'{KIND_XFER, 8'h7F, 32'h0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, ST_IDLE_REJ, 1'b0}
	};

	function automatic void emit_tx(input logic [7:0] b);
		pr.tx_valid = 1'b1;
		pr.tx_byte  = b;
	endfunction

	function automatic void end_op(input logic [2:0] st);
		seq       = SEQ_IDLE;
		pr.done   = 1'b1;
		pr.status = st;
	endfunction

	function automatic void issue_cmd(input logic [5:0] idx, input logic [31:0] arg);
		cur_idx = idx;
		cur_arg = arg;
		seq     = SEQ_READY;
		wticks  = '0;
		bcnt    = '0;
		emit_tx(BYTE_IDLE);
	endfunction

	// byte k of the six-byte command frame
	function automatic logic [7:0] frame_byte(input logic [9:0] k);
		case (k)
			10'd0: return BYTE_CMD_MARK | {2'b00, cur_idx};
			10'd1: return cur_arg[31:24];
			10'd2: return cur_arg[23:16];
			10'd3: return cur_arg[15:8];
			10'd4: return cur_arg[7:0];
			default: begin
				if (cur_idx == CMD_GO_IDLE) return CRC_CMD0;
				if (cur_idx == CMD_SEND_IF) return CRC_CMD8;
				return BYTE_IDLE;
			end
		endcase
	endfunction

	function automatic void acmd_loop();
		iticks = '0;
		issue_cmd(CMD_APP, '0);
	endfunction

	function automatic void acmd_retry();
		if (iticks >= init_tmo)
			end_op(ST_INIT_TMO);
		else
			issue_cmd(CMD_APP, '0);
	endfunction

	// r1 response handling per command
	function automatic void take_resp(input logic [7:0] r);
		case (cur_idx)
			CMD_GO_IDLE: begin
				if (r != R1_IDLE) end_op(ST_IDLE_REJ);
				else issue_cmd(CMD_SEND_IF, ARG_SEND_IF);
			end
			CMD_SEND_IF: begin
				if (r == R1_IDLE) begin
					seq  = SEQ_R7;
					bcnt = '0;
					emit_tx(BYTE_IDLE);
				end else begin
					acmd_loop();
				end
			end
			CMD_APP: issue_cmd(ACMD_OP_COND, ARG_HCS);
			ACMD_OP_COND: begin
				if (r == R1_READY) begin
					card_rdy = 1'b1;
					end_op(ST_OK);
				end else if (retry_dly == 8'd0) begin
					acmd_retry();
				end else begin
					seq    = SEQ_DELAY;
					wticks = '0;
				end
			end
			default: begin
				if (r != R1_READY) begin
					end_op(ST_READ_REJ);
				end else begin
					seq    = SEQ_TOKEN;
					wticks = '0;
					emit_tx(BYTE_IDLE);
				end
			end
		endcase
	endfunction

	// advance the host model by one input word and return its result word
	function automatic card_res_t predict_card(input logic [1:0] kind, input logic [7:0] rx,
			input logic [31:0] sector);
		logic tmo;
		pr  = '0;
		tmo = (wticks >= resp_tmo);
		case (kind)
			KIND_XFER: begin
				case (seq)
					SEQ_DUMMY: begin
						bcnt++;
						if (bcnt < DUMMY_N) emit_tx(BYTE_IDLE);
						else issue_cmd(CMD_GO_IDLE, '0);
					end
					SEQ_READY: begin
						if (rx == BYTE_IDLE || tmo) begin
							seq  = SEQ_CMD;
							bcnt = '0;
							emit_tx(frame_byte(10'd0));
						end else begin
							emit_tx(BYTE_IDLE);
						end
					end
					SEQ_CMD: begin
						bcnt++;
						if (bcnt < CMD_FRAME_BYTES) begin
							emit_tx(frame_byte(bcnt));
						end else begin
							seq    = SEQ_RESP;
							wticks = '0;
							emit_tx(BYTE_IDLE);
						end
					end
					SEQ_RESP: begin
						if (!rx[7]) take_resp(rx);
						else if (tmo) take_resp(BYTE_IDLE);
						else emit_tx(BYTE_IDLE);
					end
					SEQ_R7: begin
						bcnt++;
						if (bcnt < R7_BYTES) emit_tx(BYTE_IDLE);
						else acmd_loop();
					end
					SEQ_TOKEN: begin
						if (rx == BYTE_TOKEN) begin
							seq  = SEQ_DATA;
							bcnt = '0;
							emit_tx(BYTE_IDLE);
						end else if (tmo) begin
							end_op(ST_TOKEN_TMO);
						end else begin
							emit_tx(BYTE_IDLE);
						end
					end
					SEQ_DATA: begin
						pr.data_valid = 1'b1;
						pr.data_byte  = rx;
						pr.data_last  = (bcnt == SECT_N - 1);
						bcnt++;
						if (bcnt >= SECT_N) begin
							seq  = SEQ_CRC;
							bcnt = '0;
						end
						emit_tx(BYTE_IDLE);
					end
					SEQ_CRC: begin
						bcnt++;
						if (bcnt >= CRC_BYTES) seq = SEQ_EXTRA;
						emit_tx(BYTE_IDLE);
					end
					SEQ_EXTRA: end_op(ST_OK);
					default: ;
				endcase
			end
			KIND_INIT: begin
				if (seq == SEQ_IDLE) begin
					seq  = SEQ_DUMMY;
					bcnt = '0;
					emit_tx(BYTE_IDLE);
				end
			end
			KIND_READ: begin
				if (seq == SEQ_IDLE) begin
					if (!card_rdy) end_op(ST_NOT_READY);
					else issue_cmd(CMD_READ_BLK, sector);
				end
			end
			default: begin
				if (wticks != 16'hFFFF) wticks++;
				if (iticks != 16'hFFFF) iticks++;
				if (seq == SEQ_DELAY && wticks >= retry_dly) acmd_retry();
			end
		endcase
		pr.cs   = seq inside {SEQ_READY, SEQ_CMD, SEQ_RESP, SEQ_R7, SEQ_TOKEN, SEQ_DATA,
			SEQ_CRC};
		pr.busy = (seq != SEQ_IDLE);
		return pr;
	endfunction

	// pick the next word the way a card would answer, with some noise mixed in
	function automatic void pick_item(output logic [1:0] kind, output logic [7:0] rx,
			output logic [31:0] sector);
		int r;
		r      = $urandom_range(0, 99);
		rx     = 8'($urandom);
		sector = $urandom;
		kind   = KIND_XFER;
		if (r < 8) begin
			kind = 2'($urandom_range(0, 3));
		end else if (r < 20) begin
			kind = KIND_TICK;
		end else begin
			case (seq)
				SEQ_IDLE: kind = (!card_rdy || $urandom_range(0, 2) == 0) ? KIND_INIT : KIND_READ;
				SEQ_READY: if ($urandom_range(0, 3) != 0) rx = BYTE_IDLE;
				SEQ_RESP: begin
					if ($urandom_range(0, 3) == 0) begin
						rx[7] = 1'b1;
					end else begin
						case (cur_idx)
							CMD_GO_IDLE:  if ($urandom_range(0, 7) != 0) rx = R1_IDLE;
								else rx[7] = 1'b0;
							CMD_SEND_IF:  rx = $urandom_range(0, 1) ? R1_IDLE : 8'h05;
							CMD_APP:      rx = R1_IDLE;
							ACMD_OP_COND: rx = ($urandom_range(0, 2) == 0) ? R1_READY : R1_IDLE;
							default:      rx = ($urandom_range(0, 7) == 0) ? 8'h04 : R1_READY;
						endcase
					end
				end
				SEQ_TOKEN: begin
					if ($urandom_range(0, 2) == 0) rx = BYTE_IDLE;
					else if ($urandom_range(0, 7) != 0) rx = BYTE_TOKEN;
				end
				SEQ_DELAY: kind = KIND_TICK;
				default: ;
			endcase
		end
	endfunction

	// offer one word, recording its expected result first
	task automatic offer(input logic [1:0] kind, input logic [7:0] rx, input logic [31:0] sector,
			input card_res_t res);
		card_q.push_back(res);
		while ($urandom_range(0, 99) < src_idle) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {sector, rx};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_RESP_TMO:  resp_tmo  = val;
			REG_INIT_TMO:  init_tmo  = val;
			REG_RETRY_DLY: retry_dly = val[7:0];
			default: ;
		endcase
	endtask

	// wait until every result has come back, then let the pipeline settle
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (card_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_regs(input logic [15:0] rt, input logic [15:0] it, input logic [7:0] rd);
		write_reg(REG_RESP_TMO, rt);
		write_reg(REG_INIT_TMO, it);
		write_reg(REG_RETRY_DLY, {8'($urandom), rd});
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random(input int n);
		logic [1:0]  kind;
		logic [7:0]  rx;
		logic [31:0] sector;
		repeat (n) begin
			pick_item(kind, rx, sector);
			offer(kind, rx, sector, predict_card(kind, rx, sector));
		end
	endtask

	// receiver: random stalls plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left  <= HOLD_CYCLES;
			m_tready   <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= sink_stall);
		end
	end

	task automatic cmp(input string name, input logic [7:0] e, input logic [7:0] a);
		if (e !== a) begin
			$error("%s expected %0h got %0h", name, e, a);
			errs++;
		end
	endtask

	// compare each result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (card_q.size() == 0) begin
				$error("result word with nothing expected");
				errs++;
			end else begin
				got_exp = card_q.pop_front();
				cmp("tx_valid", 8'(got_exp.tx_valid), 8'(m_tuser[0]));
				cmp("tx_byte", got_exp.tx_byte, m_tdata[7:0]);
				cmp("cs_asserted", 8'(got_exp.cs), 8'(m_tdata[8]));
				cmp("data_valid", 8'(got_exp.data_valid), 8'(m_tuser[1]));
				cmp("data_byte", got_exp.data_byte, m_tdata[16:9]);
				cmp("data_last", 8'(got_exp.data_last), 8'(m_tlast));
				cmp("done_res", 8'(got_exp.done), 8'(m_tdata[17]));
				cmp("status", 8'(got_exp.status), 8'(m_tdata[20:18]));
				cmp("busy_res", 8'(got_exp.busy), 8'(m_tdata[21]));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	initial begin
		card_res_t res;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table at reset defaults
		foreach (dir_tab[i]) begin
			res = predict_card(dir_tab[i].kind, dir_tab[i].rx, dir_tab[i].sector);
			if (dir_tab[i].typed) begin
				res          = '0;
				res.tx_valid = dir_tab[i].tx_valid;
				res.tx_byte  = dir_tab[i].tx_byte;
				res.cs       = dir_tab[i].cs;
				res.done     = dir_tab[i].done;
				res.status   = dir_tab[i].status;
				res.busy     = dir_tab[i].busy;
			end
			offer(dir_tab[i].kind, dir_tab[i].rx, dir_tab[i].sector, res);
		end
		run_random(235);
		drain();

		// one-tick timeouts, no retry delay, sender idling
		set_regs(16'd1, 16'd1, 8'd0);
		write_reg(REG_NONE, 16'($urandom));
		@(negedge clk);
		cfg_valid <= 1'b0;
		src_idle = 65;
		run_random(235);
		drain();

		// longest timeouts and delay, receiver stalling
		set_regs(16'hFFFF, 16'hFFFF, 8'hFF);
		src_idle   = 0;
		sink_stall = 65;
		run_random(235);
		drain();

		// short timeouts, both sides idling
		set_regs(16'd3, 16'd40, 8'd2);
		src_idle   = 32;
		sink_stall = 32;
		run_random(235);
		drain();

		// long receiver hold-off while the sender keeps offering
		set_regs(16'd8, 16'd200, 8'd1);
		src_idle   = 0;
		sink_stall = 0;
		hold_req   = 1'b1;
		run_random(235);
		drain();

		repeat (8) @(posedge clk);
		if (errs == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule

### files.f
sv/sdspi_pkg.sv
sv/sd_spi_host_init_and_block_read_top.sv
sv/sdspi_port_check.sv
dv/tb.sv
